>>> rtl/globset_range_stream_parser_macros.svh
// Assertion macros shared by the range stream parser RTL.
`ifndef GLOBSET_RANGE_STREAM_PARSER_MACROS_SVH
`define GLOBSET_RANGE_STREAM_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GSRP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GSRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/gsrp_pkg.sv
// Shared constants and types of the range stream parser.
package gsrp_pkg;

    // Prefix stack depth in bytes, and the most results one item can cause.
    localparam int STACK_DEPTH      = 6;
    localparam int MAX_RESULTS      = 5;
    localparam int DEF_COUNTER_BITS = 16;

    // Command bytes.
    localparam logic [7:0] CMD_END     = 8'h00;
    localparam logic [7:0] CMD_BITMASK = 8'h42;
    localparam logic [7:0] CMD_POP     = 8'h50;
    localparam logic [7:0] CMD_RANGE   = 8'h52;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_RANGE    = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_ERROR    = 2'd2
    } kind_t;

    // Runs found in a bitmask command: run bounds are 9-bit offsets.
    typedef struct packed {
        logic [2:0]                  count;
        logic [MAX_RESULTS-1:0][8:0] lo;
        logic [MAX_RESULTS-1:0][8:0] hi;
    } run_set_t;

endpackage

>>> rtl/gsrp_mask_runs.sv
// Run extraction for the bitmask command: start value plus mask byte.
module gsrp_mask_runs (
    input  logic [7:0]          start_i,
    input  logic [7:0]          mask_i,
    output gsrp_pkg::run_set_t  runs_o
);

    // Bit j+1 of the padded vector is position start+j; position start is always set.
    always_comb begin
        logic [10:0] ext;
        logic [2:0]  idx;
        logic [8:0]  pos;
        ext    = {1'b0, mask_i, 1'b1, 1'b0};
        idx    = 3'd0;
        runs_o = '0;
        for (int j = 0; j < 9; j++) begin
            pos = 9'(start_i) + 9'(j);
            // open a run where a set bit follows a clear one
            if (ext[j+1] && !ext[j]) begin
                runs_o.lo[idx] = pos;
            end
            // close a run where a set bit precedes a clear one
            if (ext[j+1] && !ext[j+2]) begin
                runs_o.hi[idx] = pos;
                idx = idx + 3'd1;
            end
        end
        runs_o.count = idx;
    end

endmodule

>>> rtl/globset_range_stream_parser.sv
// Top level of the range stream parser: command decode, prefix stack and result buffer.
// Takes one command byte per cycle while s_tready is high and decodes it in a single
// registered pass. A byte causes zero or one result in most cases; its results are held
// in a small result buffer and leave on the single result port one per cycle while
// m_tready is high. A byte with no result does not hold off the next item; a byte with
// results (a bitmask command gives up to five) holds it off until its last one leaves,
// and the next item may enter in that cycle. There is no start-up pass after reset.
module globset_range_stream_parser #(
    parameter int COUNTER_BITS = gsrp_pkg::DEF_COUNTER_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,   // buffer_end
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [47:0] range_low, [95:48] range_high,
                                    // [111:96] range_total, [127:112] bytes_used
    output logic [1:0]   m_tuser,   // [1:0] kind
    output logic         m_tlast    // last
);

    localparam int                DEPTH   = gsrp_pkg::STACK_DEPTH;
    localparam int                NRES    = gsrp_pkg::MAX_RESULTS;
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

    typedef enum logic [2:0] {
        PH_CMD    = 3'd0,
        PH_PUSH   = 3'd1,
        PH_LOW    = 3'd2,
        PH_HIGH   = 3'd3,
        PH_BSTART = 3'd4,
        PH_BMASK  = 3'd5
    } phase_t;

    // Parser state
    logic [7:0]              prefix_bytes_reg  [DEPTH];
    logic [7:0]              prefix_bytes_next [DEPTH];
    logic [2:0]              entry_lengths_reg [DEPTH];
    logic [2:0]              entry_lengths_next[DEPTH];
    logic [2:0]              entry_count_reg,  entry_count_next;
    logic [2:0]              prefix_total_reg, prefix_total_next;
    phase_t                  phase_reg,        phase_next;
    logic [2:0]              bytes_left_reg,   bytes_left_next;
    logic [47:0]             low_collect_reg,  low_collect_next;
    logic [47:0]             high_collect_reg, high_collect_next;
    logic [7:0]              mask_start_reg,   mask_start_next;
    logic [COUNTER_BITS-1:0] range_counter_reg, range_counter_next;
    logic [COUNTER_BITS-1:0] byte_counter_reg,  byte_counter_next;

    // Result buffer
    logic [47:0]             res_low_reg  [NRES];
    logic [47:0]             res_low_next [NRES];
    logic [47:0]             res_high_reg [NRES];
    logic [47:0]             res_high_next[NRES];
    gsrp_pkg::kind_t         kind_reg,  kind_next;
    logic [15:0]             total_reg, total_next;
    logic [15:0]             used_reg,  used_next;
    logic [2:0]              res_count_reg, res_count_next;
    logic [2:0]              rd_idx_reg;

    // Handshake
    logic                    in_accept;
    logic                    out_take;
    logic                    last_take;

    // Decode helpers
    gsrp_pkg::run_set_t      runs;
    logic [47:0]             prefix_cur;
    logic [47:0]             mask_base;
    logic [2:0]              pos_push;
    logic [2:0]              pos_col;
    logic [2:0]              left_dec;
    logic [2:0]              count_dec;
    logic [2:0]              n_rng;
    logic [47:0]             rng_low [NRES];
    logic [47:0]             rng_high[NRES];
    logic                    is_done;
    logic                    is_err;
    logic [COUNTER_BITS:0]   range_sum;
    logic [31:0]             range_wide;
    logic [31:0]             byte_wide;

    gsrp_mask_runs u_runs (
        .start_i (mask_start_reg),
        .mask_i  (s_tdata),
        .runs_o  (runs)
    );

    // Accept an item when the buffer is empty or its last result leaves now
    assign out_take  = m_tvalid && m_tready;
    assign last_take = out_take && (rd_idx_reg == res_count_reg - 3'd1);
    assign s_tready  = (res_count_reg == 3'd0) || last_take;
    assign in_accept = s_tvalid && s_tready;

    // Present the result at the read index
    assign m_tvalid = (res_count_reg != 3'd0);
    assign m_tdata  = {used_reg, total_reg, res_high_reg[rd_idx_reg], res_low_reg[rd_idx_reg]};
    assign m_tuser  = kind_reg;
    assign m_tlast  = (rd_idx_reg == res_count_reg - 3'd1);

    // Assemble the prefix value from the bytes below the stack top
    always_comb begin
        prefix_cur = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (3'(i) < prefix_total_reg) begin
                prefix_cur[8*i +: 8] = prefix_bytes_reg[i];
            end
        end
    end

    assign mask_base = {prefix_cur[39:0], 8'h00};
    assign pos_push  = prefix_total_reg - bytes_left_reg;
    assign pos_col   = 3'(DEPTH) - bytes_left_reg;
    assign left_dec  = bytes_left_reg - 3'd1;
    assign count_dec = entry_count_reg - 3'd1;

    // Decode one byte against the current phase
    always_comb begin
        prefix_bytes_next  = prefix_bytes_reg;
        entry_lengths_next = entry_lengths_reg;
        entry_count_next   = entry_count_reg;
        prefix_total_next  = prefix_total_reg;
        phase_next         = phase_reg;
        bytes_left_next    = bytes_left_reg;
        low_collect_next   = low_collect_reg;
        high_collect_next  = high_collect_reg;
        mask_start_next    = mask_start_reg;
        n_rng              = 3'd0;
        is_done            = 1'b0;
        is_err             = 1'b0;
        for (int k = 0; k < NRES; k++) begin
            rng_low[k]  = '0;
            rng_high[k] = '0;
        end

        unique case (phase_reg)
            PH_PUSH: begin
                if (pos_push < 3'(DEPTH)) begin
                    prefix_bytes_next[pos_push] = s_tdata;
                end
                bytes_left_next = left_dec;
                if (left_dec == 3'd0) begin
                    phase_next = PH_CMD;
                    // full stack: emit a singleton and drop the top entry
                    if (prefix_total_reg == 3'(DEPTH)) begin
                        n_rng       = 3'd1;
                        rng_low[0]  = {prefix_bytes_next[5], prefix_bytes_next[4],
                                       prefix_bytes_next[3], prefix_bytes_next[2],
                                       prefix_bytes_next[1], prefix_bytes_next[0]};
                        rng_high[0] = rng_low[0];
                        if (entry_count_reg != 3'd0 && entry_count_reg <= 3'(DEPTH)) begin
                            entry_count_next  = count_dec;
                            prefix_total_next = prefix_total_reg
                                                - entry_lengths_reg[count_dec];
                        end
                    end
                end
            end
            PH_LOW, PH_HIGH: begin
                if (pos_col < 3'(DEPTH)) begin
                    if (phase_reg == PH_LOW) begin
                        low_collect_next[{pos_col, 3'b000} +: 8] =
                            low_collect_reg[{pos_col, 3'b000} +: 8] | s_tdata;
                    end else begin
                        high_collect_next[{pos_col, 3'b000} +: 8] =
                            high_collect_reg[{pos_col, 3'b000} +: 8] | s_tdata;
                    end
                end
                bytes_left_next = left_dec;
                if (left_dec == 3'd0) begin
                    if (phase_reg == PH_LOW) begin
                        phase_next      = PH_HIGH;
                        bytes_left_next = 3'(DEPTH) - prefix_total_reg;
                    end else begin
                        phase_next  = PH_CMD;
                        n_rng       = 3'd1;
                        rng_low[0]  = low_collect_reg;
                        rng_high[0] = high_collect_next;
                    end
                end
            end
            PH_BSTART: begin
                mask_start_next = s_tdata;
                phase_next      = PH_BMASK;
            end
            PH_BMASK: begin
                n_rng = runs.count;
                for (int k = 0; k < NRES; k++) begin
                    rng_low[k]  = mask_base | 48'(runs.lo[k]);
                    rng_high[k] = mask_base | 48'(runs.hi[k]);
                end
                phase_next = PH_CMD;
            end
            default: begin
                // expect a command
                priority if (s_tdata == gsrp_pkg::CMD_END) begin
                    is_done = 1'b1;
                end else if (s_tdata >= 8'd1 && s_tdata <= 8'(DEPTH)) begin
                    if ((4'(prefix_total_reg) + 4'(s_tdata[2:0]) > 4'(DEPTH))
                        || (entry_count_reg >= 3'(DEPTH))) begin
                        is_err = 1'b1;
                    end else begin
                        entry_lengths_next[entry_count_reg] = s_tdata[2:0];
                        entry_count_next  = entry_count_reg + 3'd1;
                        prefix_total_next = prefix_total_reg + s_tdata[2:0];
                        bytes_left_next   = s_tdata[2:0];
                        phase_next        = PH_PUSH;
                    end
                end else if (s_tdata == gsrp_pkg::CMD_POP) begin
                    if (entry_count_reg == 3'd0 || entry_count_reg > 3'(DEPTH)) begin
                        is_err = 1'b1;
                    end else begin
                        entry_count_next  = count_dec;
                        prefix_total_next = prefix_total_reg - entry_lengths_reg[count_dec];
                    end
                end else if (s_tdata == gsrp_pkg::CMD_RANGE) begin
                    if (prefix_total_reg >= 3'(DEPTH)) begin
                        is_err = 1'b1;
                    end else begin
                        low_collect_next  = prefix_cur;
                        high_collect_next = prefix_cur;
                        bytes_left_next   = 3'(DEPTH) - prefix_total_reg;
                        phase_next        = PH_LOW;
                    end
                end else if (s_tdata == gsrp_pkg::CMD_BITMASK) begin
                    phase_next = PH_BSTART;
                end else begin
                    is_err = 1'b1;
                end
            end
        endcase

        // Advance the saturating counters
        range_sum = {1'b0, range_counter_reg} + (COUNTER_BITS+1)'(n_rng);
        range_counter_next = range_sum[COUNTER_BITS] ? CNT_MAX : range_sum[COUNTER_BITS-1:0];
        byte_counter_next  = (byte_counter_reg == CNT_MAX) ? CNT_MAX
                                                           : byte_counter_reg + COUNTER_BITS'(1);
        range_wide = 32'(range_counter_next);
        byte_wide  = 32'(byte_counter_next);

        // Build the result set of this item
        res_count_next = n_rng;
        kind_next      = gsrp_pkg::KIND_RANGE;
        total_next     = 16'd0;
        used_next      = 16'd0;
        res_low_next   = rng_low;
        res_high_next  = rng_high;
        if (is_done || is_err || s_tlast) begin
            res_count_next   = 3'd1;
            res_low_next[0]  = '0;
            res_high_next[0] = '0;
            if (is_done) begin
                kind_next  = gsrp_pkg::KIND_COMPLETE;
                total_next = (range_wide > 32'h0000_FFFF) ? 16'hFFFF : range_wide[15:0];
                used_next  = (byte_wide > 32'h0000_FFFF) ? 16'hFFFF : byte_wide[15:0];
            end else begin
                kind_next = gsrp_pkg::KIND_ERROR;
            end
            // restart the parser
            entry_count_next   = 3'd0;
            prefix_total_next  = 3'd0;
            phase_next         = PH_CMD;
            bytes_left_next    = 3'd0;
            range_counter_next = '0;
            byte_counter_next  = '0;
        end
    end

    // Hold parser state and the result buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg   <= 3'd0;
            prefix_total_reg  <= 3'd0;
            phase_reg         <= PH_CMD;
            bytes_left_reg    <= 3'd0;
            range_counter_reg <= '0;
            byte_counter_reg  <= '0;
            res_count_reg     <= 3'd0;
            rd_idx_reg        <= 3'd0;
        end else if (in_accept) begin
            prefix_bytes_reg  <= prefix_bytes_next;
            entry_lengths_reg <= entry_lengths_next;
            entry_count_reg   <= entry_count_next;
            prefix_total_reg  <= prefix_total_next;
            phase_reg         <= phase_next;
            bytes_left_reg    <= bytes_left_next;
            low_collect_reg   <= low_collect_next;
            high_collect_reg  <= high_collect_next;
            mask_start_reg    <= mask_start_next;
            range_counter_reg <= range_counter_next;
            byte_counter_reg  <= byte_counter_next;
            res_low_reg       <= res_low_next;
            res_high_reg      <= res_high_next;
            kind_reg          <= kind_next;
            total_reg         <= total_next;
            used_reg          <= used_next;
            res_count_reg     <= res_count_next;
            rd_idx_reg        <= 3'd0;
        end else if (last_take) begin
            res_count_reg <= 3'd0;
            rd_idx_reg    <= 3'd0;
        end else if (out_take) begin
            rd_idx_reg <= rd_idx_reg + 3'd1;
        end
    end

    `include "globset_range_stream_parser_macros.svh"

    `GSRP_ASSERT_IMP(a_rd_idx_in_set, aclk, aresetn, res_count_reg != 3'd0, rd_idx_reg < res_count_reg, "read index past result count")
    `GSRP_ASSERT_IMP(a_set_single_status, aclk, aresetn, res_count_reg != 3'd0 && kind_reg != gsrp_pkg::KIND_RANGE, res_count_reg == 3'd1, "status result shares its set")
    `GSRP_ASSERT_IMP(a_stack_consistent, aclk, aresetn, 1'b1, entry_count_reg <= prefix_total_reg && prefix_total_reg <= 3'(DEPTH), "prefix stack bookkeeping broken")
    `GSRP_ASSERT_NEXT(a_restart_on_end, aclk, aresetn, in_accept && s_tlast, phase_reg == PH_CMD && entry_count_reg == 3'd0, "parser not restarted at buffer end")

endmodule
